[rtl/rc4_pkg.sv]
`default_nettype none

package rc4_pkg;

   localparam int PERM_SIZE = 256;

   typedef logic [7:0] byte_type;

   typedef enum logic {
      KIND_KEY  = 1'b0,
      KIND_DATA = 1'b1
   } kind_type;

endpackage

`default_nettype wire

[rtl/rc4_ram.sv]
`default_nettype none

module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/rc4_keystream_cipher.sv]
// a data request with a key passes DAT_RD_I, DAT_RD_J, DAT_WR_I, DAT_WR_J, DAT_RD_T, DAT_KS
// and OUT; a request without a key goes straight to OUT; key byte requests give no result
// OUT registers the result when the output is free; a new request is taken only after that
// last key byte: identity refill of the permutation, then the key schedule, no requests taken
// reset: synchronous; an identity fill of the permutation runs before req_ready
`default_nettype none

module rc4_keystream_cipher #(
   parameter int KEY_DEPTH = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_kind,
   input  wire rc4_pkg::byte_type req_byte_in,
   input  wire logic              req_last_key,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rc4_pkg::byte_type      rsp_byte_out,
   output logic                   rsp_no_key
);

   import rc4_pkg::*;

   localparam int KW = KEY_DEPTH > 1 ? $clog2(KEY_DEPTH) : 1;
   localparam int LW = $clog2(KEY_DEPTH + 1);
   localparam int PW = LW + 1;
   localparam logic [LW-1:0] KEY_DEPTH_L = LW'(KEY_DEPTH);

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCH_RD_N,
      ST_SCH_RD_J,
      ST_SCH_WR_N,
      ST_SCH_WR_J,
      ST_DAT_RD_I,
      ST_DAT_RD_J,
      ST_DAT_WR_I,
      ST_DAT_WR_J,
      ST_DAT_RD_T,
      ST_DAT_KS,
      ST_OUT
   } state_type;

   state_type      state_ff;
   logic [7:0]     cnt_ff;
   logic           sched_ff;
   logic [LW-1:0]  key_len_ff;
   logic [KW-1:0]  pos_ff;
   byte_type       acc_ff;
   byte_type       i_ff;
   byte_type       j_ff;
   byte_type       si_ff;
   byte_type       sj_ff;
   byte_type       ks_ff;
   byte_type       din_ff;
   logic           nk_ff;
   logic           key_ready_ff;
   logic           rsp_valid_ff;
   byte_type       rsp_byte_out_ff;
   logic           rsp_no_key_ff;

   logic           perm_wr_en;
   byte_type       perm_wr_addr;
   byte_type       perm_wr_data;
   byte_type       perm_rd_addr;
   byte_type       perm_rd_data;
   logic           key_wr_en;
   byte_type       key_rd_data;

   byte_type       acc_in;
   byte_type       j_in;
   logic           pos_wrap;
   logic           req_take;
   logic           out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign acc_in    = acc_ff + perm_rd_data + key_rd_data;
   assign j_in      = j_ff + perm_rd_data;
   assign pos_wrap  = (PW'(pos_ff) + PW'(1)) >= PW'(key_len_ff);
   assign key_wr_en = req_take && (req_kind == KIND_KEY) && (key_len_ff < KEY_DEPTH_L);

   always_comb begin
      perm_wr_en   = 1'b0;
      perm_wr_addr = cnt_ff;
      perm_wr_data = cnt_ff;
      perm_rd_addr = cnt_ff;
      case (state_ff)
         ST_INIT: begin
            perm_wr_en = 1'b1;
         end
         ST_SCH_RD_J: begin
            perm_rd_addr = acc_in;
         end
         ST_SCH_WR_N: begin
            perm_wr_en   = 1'b1;
            perm_wr_data = perm_rd_data;
         end
         ST_SCH_WR_J: begin
            perm_wr_en   = 1'b1;
            perm_wr_addr = acc_ff;
            perm_wr_data = si_ff;
         end
         ST_DAT_RD_I: begin
            perm_rd_addr = i_ff;
         end
         ST_DAT_RD_J: begin
            perm_rd_addr = j_in;
         end
         ST_DAT_WR_I: begin
            perm_wr_en   = 1'b1;
            perm_wr_addr = i_ff;
            perm_wr_data = perm_rd_data;
         end
         ST_DAT_WR_J: begin
            perm_wr_en   = 1'b1;
            perm_wr_addr = j_ff;
            perm_wr_data = si_ff;
         end
         ST_DAT_RD_T: begin
            perm_rd_addr = si_ff + sj_ff;
         end
         default: begin
            perm_wr_en = 1'b0;
         end
      endcase
   end

   rc4_ram #(
      .WIDTH(8),
      .DEPTH(PERM_SIZE)
   ) u_perm_ram (
      .clock  (clock),
      .wr_en  (perm_wr_en),
      .wr_addr(perm_wr_addr),
      .wr_data(perm_wr_data),
      .rd_addr(perm_rd_addr),
      .rd_data(perm_rd_data)
   );

   rc4_ram #(
      .WIDTH(8),
      .DEPTH(KEY_DEPTH)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (key_wr_en),
      .wr_addr(key_len_ff[KW-1:0]),
      .wr_data(req_byte_in),
      .rd_addr(pos_ff),
      .rd_data(key_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         sched_ff     <= 1'b0;
         key_len_ff   <= '0;
         pos_ff       <= '0;
         acc_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         key_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_INIT: begin
               cnt_ff <= cnt_ff + 8'd1;
               if (cnt_ff == 8'hFF) begin
                  acc_ff   <= '0;
                  pos_ff   <= '0;
                  state_ff <= sched_ff ? ST_SCH_RD_N : ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_take) begin
                  din_ff <= req_byte_in;
                  if (req_kind == KIND_KEY) begin
                     if (key_len_ff < KEY_DEPTH_L) begin
                        key_len_ff <= key_len_ff + LW'(1);
                     end
                     if (req_last_key) begin
                        sched_ff <= 1'b1;
                        cnt_ff   <= '0;
                        state_ff <= ST_INIT;
                     end
                  end else if (!key_ready_ff) begin
                     ks_ff    <= '0;
                     nk_ff    <= 1'b1;
                     state_ff <= ST_OUT;
                  end else begin
                     i_ff     <= i_ff + 8'd1;
                     nk_ff    <= 1'b0;
                     state_ff <= ST_DAT_RD_I;
                  end
               end
            end
            ST_SCH_RD_N: begin
               state_ff <= ST_SCH_RD_J;
            end
            ST_SCH_RD_J: begin
               acc_ff   <= acc_in;
               si_ff    <= perm_rd_data;
               state_ff <= ST_SCH_WR_N;
            end
            ST_SCH_WR_N: begin
               state_ff <= ST_SCH_WR_J;
            end
            ST_SCH_WR_J: begin
               cnt_ff <= cnt_ff + 8'd1;
               pos_ff <= pos_wrap ? '0 : pos_ff + KW'(1);
               if (cnt_ff == 8'hFF) begin
                  i_ff         <= '0;
                  j_ff         <= '0;
                  key_len_ff   <= '0;
                  key_ready_ff <= 1'b1;
                  sched_ff     <= 1'b0;
                  state_ff     <= ST_IDLE;
               end else begin
                  state_ff <= ST_SCH_RD_N;
               end
            end
            ST_DAT_RD_I: begin
               state_ff <= ST_DAT_RD_J;
            end
            ST_DAT_RD_J: begin
               j_ff     <= j_in;
               si_ff    <= perm_rd_data;
               state_ff <= ST_DAT_WR_I;
            end
            ST_DAT_WR_I: begin
               sj_ff    <= perm_rd_data;
               state_ff <= ST_DAT_WR_J;
            end
            ST_DAT_WR_J: begin
               state_ff <= ST_DAT_RD_T;
            end
            ST_DAT_RD_T: begin
               state_ff <= ST_DAT_KS;
            end
            ST_DAT_KS: begin
               ks_ff    <= perm_rd_data;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_byte_out_ff <= din_ff ^ ks_ff;
                  rsp_no_key_ff   <= nk_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_byte_out = rsp_byte_out_ff;
   assign rsp_no_key   = rsp_no_key_ff;

   // keyed results only once a schedule has completed
   a_keyed_needs_key : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_no_key_ff) |-> key_ready_ff)
      else $error("keyed result without a scheduled key");

   // no permutation write while a request is taken
   a_no_write_on_take : assert property (@(posedge clock) disable iff (reset)
      req_take |-> !perm_wr_en)
      else $error("permutation write during request acceptance");

   a_key_len_bound : assert property (@(posedge clock) disable iff (reset)
      key_len_ff <= KEY_DEPTH_L)
      else $error("key length beyond key store depth");

   // generator index steps once per keyed data request
   a_index_step : assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_kind == KIND_DATA) && key_ready_ff)
         |=> (i_ff == 8'($past(i_ff) + 8'd1)))
      else $error("index i did not advance");

endmodule

`default_nettype wire

[bench/rc4_keystream_cipher_tb.sv]
`default_nettype none

module rc4_keystream_cipher_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import rc4_pkg::*;

   localparam int KEY_DEPTH   = 256;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int RANDOM_ITEMS = 1340;

   typedef struct packed {
      byte_type byte_out;
      logic     no_key;
   } cipher_result_type;

   logic     clock        = 1'b0;
   logic     reset        = 1'b1;
   logic     req_valid    = 1'b0;
   logic     req_kind     = KIND_KEY;
   byte_type req_byte_in  = 8'h00;
   logic     req_last_key = 1'b0;
   logic     rsp_ready    = 1'b0;
   logic     req_ready;
   logic     rsp_valid;
   byte_type rsp_byte_out;
   logic     rsp_no_key;

   // predicted cipher state
   byte_type    perm_copy [PERM_SIZE];
   byte_type    key_copy [KEY_DEPTH];
   int unsigned key_count;
   byte_type    stream_i;
   byte_type    stream_j;
   bit          key_loaded;

   cipher_result_type expected_results [$];

   int unsigned cycle_count    = 0;
   int unsigned mismatch_count = 0;
   int unsigned sent_count     = 0;
   int unsigned checked_count  = 0;
   int unsigned keys_scheduled = 0;
   int unsigned passthru_count = 0;

   // receiver and sender pacing
   bit          calm         = 1'b0;
   int unsigned hold_request = 0;
   int unsigned hold_left    = 0;
   int unsigned ready_left   = 0;
   bit          ready_level  = 1'b1;

   rc4_keystream_cipher #(
      .KEY_DEPTH(KEY_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_byte_in(req_byte_in),
      .req_last_key(req_last_key),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_byte_out(rsp_byte_out),
      .rsp_no_key(rsp_no_key)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("status: fail");
         $finish;
      end
   end

   // receiver pacing
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         if (ready_left == 0) begin
            ready_level = ($urandom_range(0, 99) < 65);
            if (ready_level)
               ready_left = $urandom_range(1, 20);
            else if ($urandom_range(0, 99) < 90)
               ready_left = $urandom_range(1, 4);
            else
               ready_left = $urandom_range(20, 60);
         end
         ready_left = ready_left - 1;
         rsp_ready <= ready_level;
      end
   end

   // result checker
   always @(posedge clock) begin
      cipher_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
               $display("unexpected result: byte_out %02h no_key %0b",
                        rsp_byte_out, rsp_no_key);
         end else begin
            want = expected_results.pop_front();
            checked_count = checked_count + 1;
            if (want.byte_out !== rsp_byte_out || want.no_key !== rsp_no_key) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("result %0d: expected %02h/%0b, got %02h/%0b",
                           checked_count, want.byte_out, want.no_key,
                           rsp_byte_out, rsp_no_key);
            end
         end
      end
   end

   function automatic void run_key_schedule();
      int unsigned len;
      int unsigned pos;
      byte_type    acc;
      byte_type    tmp;
      len = key_count;
      if (len == 0 || len > KEY_DEPTH)
         len = KEY_DEPTH;
      for (int n = 0; n < PERM_SIZE; n++)
         perm_copy[n] = byte_type'(n);
      acc = 8'h00;
      pos = 0;
      for (int n = 0; n < PERM_SIZE; n++) begin
         acc = acc + perm_copy[n] + key_copy[pos];
         tmp = perm_copy[n];
         perm_copy[n] = perm_copy[acc];
         perm_copy[acc] = tmp;
         pos = pos + 1;
         if (pos >= len)
            pos = 0;
      end
      stream_i = 8'h00;
      stream_j = 8'h00;
      key_count = 0;
      key_loaded = 1'b1;
      keys_scheduled = keys_scheduled + 1;
   endfunction

   function automatic void predict_request(kind_type kind, byte_type data, logic last);
      cipher_result_type res;
      byte_type          tmp;
      byte_type          sum;
      if (kind == KIND_KEY) begin
         if (key_count < KEY_DEPTH) begin
            key_copy[key_count] = data;
            key_count = key_count + 1;
         end
         if (last)
            run_key_schedule();
      end else if (!key_loaded) begin
         res.byte_out = data;
         res.no_key = 1'b1;
         passthru_count = passthru_count + 1;
         expected_results = {expected_results, res};
      end else begin
         stream_i = stream_i + 8'd1;
         stream_j = stream_j + perm_copy[stream_i];
         tmp = perm_copy[stream_i];
         perm_copy[stream_i] = perm_copy[stream_j];
         perm_copy[stream_j] = tmp;
         sum = perm_copy[stream_i] + perm_copy[stream_j];
         res.byte_out = perm_copy[sum] ^ data;
         res.no_key = 1'b0;
         expected_results = {expected_results, res};
      end
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   task automatic send_request(kind_type kind, byte_type data, logic last);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_byte_in  <= data;
      req_last_key <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_request(kind, data, last);
      sent_count = sent_count + 1;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_key(int unsigned len);
      for (int unsigned n = 0; n < len; n++)
         send_request(KIND_KEY, byte_type'($urandom_range(0, 255)), n == len - 1);
   endtask

   task automatic send_data(int unsigned count);
      for (int unsigned n = 0; n < count; n++)
         send_request(KIND_DATA, byte_type'($urandom_range(0, 255)),
                      logic'($urandom_range(0, 1)));
   endtask

   task automatic test_no_key_passthrough();
      send_request(KIND_DATA, 8'h00, 1'b0);
      send_request(KIND_DATA, 8'hff, 1'b1);
      send_request(KIND_DATA, 8'ha5, 1'b0);
      send_request(KIND_DATA, 8'h5a, 1'b1);
   endtask

   task automatic test_single_byte_keys();
      send_request(KIND_KEY, 8'h00, 1'b1);
      send_request(KIND_DATA, 8'h00, 1'b0);
      send_request(KIND_DATA, 8'hff, 1'b0);
      send_request(KIND_DATA, 8'h00, 1'b1);
      send_request(KIND_KEY, 8'hff, 1'b1);
      send_request(KIND_DATA, 8'h00, 1'b0);
      send_request(KIND_DATA, 8'hff, 1'b0);
   endtask

   task automatic test_key_handover();
      // old key stays in use while new key bytes collect
      send_request(KIND_KEY, 8'h4b, 1'b0);
      send_request(KIND_KEY, 8'h65, 1'b0);
      send_request(KIND_KEY, 8'h79, 1'b1);
      send_request(KIND_DATA, 8'h50, 1'b0);
      send_request(KIND_DATA, 8'h6c, 1'b1);
      send_request(KIND_KEY, 8'h80, 1'b0);
      send_request(KIND_KEY, 8'h01, 1'b0);
      send_request(KIND_DATA, 8'h61, 1'b0);
      send_request(KIND_DATA, 8'h69, 1'b1);
      send_request(KIND_KEY, 8'h7f, 1'b1);
      send_request(KIND_DATA, 8'h6e, 1'b0);
      send_request(KIND_DATA, 8'hff, 1'b0);
   endtask

   task automatic test_key_store_full();
      // bytes past the store depth are dropped; the last one still schedules
      for (int unsigned n = 0; n < KEY_DEPTH; n++)
         send_request(KIND_KEY, byte_type'(n == 0 ? 8'hff : $urandom_range(0, 255)), 1'b0);
      send_request(KIND_KEY, 8'h00, 1'b0);
      send_request(KIND_KEY, 8'hff, 1'b0);
      send_request(KIND_KEY, 8'h3c, 1'b1);
      send_data(12);
   endtask

   task automatic test_back_pressure();
      wait_for_results();
      calm = 1'b1;
      hold_request = 400;
      send_data(40);
      wait_for_results();
      calm = 1'b0;
      hold_request = 150;
      send_key(5);
      send_data(25);
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      int unsigned start;
      int unsigned choice;
      int unsigned len;
      int unsigned mix;
      start = sent_count;
      while (sent_count - start < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 7) == 0);
         choice = $urandom_range(0, 99);
         if (choice < 75) begin
            len = $urandom_range(0, 99);
            if (len < 80)
               len = $urandom_range(1, 16);
            else if (len < 98)
               len = $urandom_range(17, 64);
            else
               len = $urandom_range(100, 256);
            send_key(len);
            send_data($urandom_range(4, 40));
         end else if (choice < 88) begin
            // partial key, then data on the old key
            for (int unsigned n = $urandom_range(1, 5); n > 0; n--)
               send_request(KIND_KEY, byte_type'($urandom_range(0, 255)), 1'b0);
            send_data($urandom_range(1, 10));
         end else begin
            for (int unsigned n = $urandom_range(1, 10); n > 0; n--) begin
               mix = $urandom_range(0, 3);
               send_request(kind_type'(mix == 0 ? KIND_KEY : KIND_DATA),
                            byte_type'($urandom_range(0, 255)),
                            logic'($urandom_range(0, 7) == 0));
            end
         end
         if ($urandom_range(0, 29) == 0)
            wait_for_results();
      end
      calm = 1'b0;
   endtask

   initial begin
      for (int n = 0; n < PERM_SIZE; n++)
         perm_copy[n] = byte_type'(n);
      for (int n = 0; n < KEY_DEPTH; n++)
         key_copy[n] = 8'h00;
      key_count = 0;
      stream_i = 8'h00;
      stream_j = 8'h00;
      key_loaded = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_no_key_passthrough();
      test_single_byte_keys();
      test_key_handover();
      test_key_store_full();
      test_back_pressure();
      test_random_traffic();

      wait_for_results();
      repeat (40) @(posedge clock);

      $display("sent %0d requests, checked %0d results (%0d without key), %0d keys scheduled",
               sent_count, checked_count, passthru_count, keys_scheduled);
      $display("covered pass-through, one-byte and full-store keys, key handover and stalls");
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count,
                  expected_results.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
